// ----- rtl/thcg_pkg.sv -----
// Shared types, codes and reset values for the touch/hold/click gesture block.
package thcg_pkg;

  localparam int DEF_COUNT_WIDTH = 8;
  localparam int DEF_TIME_WIDTH  = 32;

  localparam int CLASS_W  = 2;
  localparam int STAMP_W  = 32;
  localparam int STATE_W  = 3;
  localparam int EVENT_W  = 3;
  localparam int THR_W    = 8;
  localparam int MS_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CLASS_W-1:0] {
    CLS_NONE    = 2'd0,
    CLS_CONTACT = 2'd1,
    CLS_UP      = 2'd2,
    CLS_DOWN    = 2'd3
  } hand_class_t;

  typedef enum logic [STATE_W-1:0] {
    ST_FREE      = 3'd0,
    ST_TOUCH     = 3'd1,
    ST_HELD_INIT = 3'd2,
    ST_DOWN      = 3'd3,
    ST_UP        = 3'd4
  } hold_state_t;

  typedef enum logic [EVENT_W-1:0] {
    EV_NONE    = 3'd0,
    EV_TOUCH   = 3'd1,
    EV_HOLD    = 3'd2,
    EV_RELEASE = 3'd3,
    EV_CLICK   = 3'd4
  } event_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TOUCH_COUNT       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_COUNT        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TIME_MS      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_COUNT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FINGER_DOWN_COUNT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FINGER_UP_COUNT   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CLICK_WINDOW_MS   = 3'd6;

  localparam logic [THR_W-1:0] RST_TOUCH_COUNT       = 8'd3;
  localparam logic [THR_W-1:0] RST_HOLD_COUNT        = 8'd7;
  localparam logic [MS_W-1:0]  RST_HOLD_TIME_MS      = 16'd300;
  localparam logic [THR_W-1:0] RST_RELEASE_COUNT     = 8'd2;
  localparam logic [THR_W-1:0] RST_FINGER_DOWN_COUNT = 8'd3;
  localparam logic [THR_W-1:0] RST_FINGER_UP_COUNT   = 8'd3;
  localparam logic [MS_W-1:0]  RST_CLICK_WINDOW_MS   = 16'd10000;

  typedef struct packed {
    logic [THR_W-1:0] touch_count;
    logic [THR_W-1:0] hold_count;
    logic [MS_W-1:0]  hold_time_ms;
    logic [THR_W-1:0] release_count;
    logic [THR_W-1:0] finger_down_count;
    logic [THR_W-1:0] finger_up_count;
    logic [MS_W-1:0]  click_window_ms;
  } cfg_t;

endpackage

// ----- rtl/thcg_sample_if.sv -----
// Sample channel: one classified hand sample with its timestamp.
interface thcg_sample_if import thcg_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CLASS_W-1:0] hand_class;
  logic [STAMP_W-1:0] time_ms;

  modport source (output valid, hand_class, time_ms, input ready);
  modport sink   (input valid, hand_class, time_ms, output ready);
endinterface

// ----- rtl/thcg_result_if.sv -----
// Result channel: state after the sample and the event it raised.
interface thcg_result_if import thcg_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [STATE_W-1:0] hold_state;
  logic [EVENT_W-1:0] event_code;

  modport source (output valid, hold_state, event_code, input ready);
  modport sink   (input valid, hold_state, event_code, output ready);
endinterface

// ----- rtl/touch_hold_click_gesture_fsm_core.sv -----
// Touch/hold/click gesture recognizer: debounce state machine and result register.
//
// Usage:
//   sample  (sink)  : hand_class (0 none, 1 contact, 2 finger up, 3 finger down)
//                     and a free-running millisecond timestamp time_ms.
//   result  (source): hold_state and event_code for every sample, in order.
//   cfg_we/cfg_index/cfg_data: write-only thresholds, index 0..6, taken on
//   any clock with cfg_we high; write them only while the block is idle.
// Timing:
//   One sample per cycle unless the result register stalls. The state
//   machine updates in the cycle a request is accepted and its result
//   appears in the output register on the next cycle.
//   The result register is the only buffer: sample.ready stays high while
//   it is empty or being drained, and drops only when a result waits and
//   result.ready is low. Nothing is lost or repeated under stalls.
// Reset (rst, synchronous): state free, run counters and change time cleared,
//   thresholds back to their defaults, result register empty.
module touch_hold_click_gesture_fsm_core import thcg_pkg::*; #(
  parameter int COUNT_WIDTH = DEF_COUNT_WIDTH,
  parameter int TIME_WIDTH  = DEF_TIME_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  thcg_sample_if.sink           sample,
  thcg_result_if.source         result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CMP_W = (COUNT_WIDTH > THR_W) ? COUNT_WIDTH : THR_W;

  typedef logic [COUNT_WIDTH-1:0] run_t;

  function automatic run_t sat_inc(input run_t v);
    return (&v) ? v : v + run_t'(1);
  endfunction

  function automatic logic reached(input run_t run, input logic [THR_W-1:0] thr);
    return CMP_W'(run) >= CMP_W'(thr);
  endfunction

  cfg_t cfg;

  thcg_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  hold_state_t            state, state_next;
  hold_state_t            prev_state, prev_state_next;
  run_t                   contact_run, contact_run_next;
  run_t                   release_run, release_run_next;
  run_t                   up_run, up_run_next;
  run_t                   down_run, down_run_next;
  logic [TIME_WIDTH-1:0]  change_time, change_time_next;
  event_t                 ev;

  logic                   out_valid;
  hold_state_t            out_state;
  event_t                 out_event;

  logic                   accept;
  hand_class_t            cls;
  logic [TIME_WIDTH-1:0]  now;
  logic [TIME_WIDTH-1:0]  elapsed;
  run_t                   contact_inc, release_inc, up_inc, down_inc;

  assign sample.ready = !out_valid || result.ready;
  assign accept       = sample.valid && sample.ready;
  assign cls          = hand_class_t'(sample.hand_class);
  assign now          = TIME_WIDTH'(sample.time_ms);
  assign elapsed      = now - change_time;
  assign contact_inc  = sat_inc(contact_run);
  assign release_inc  = sat_inc(release_run);
  assign up_inc       = sat_inc(up_run);
  assign down_inc     = sat_inc(down_run);

  always_comb begin
    logic              jump;
    hold_state_t       target;
    state_next       = state;
    prev_state_next  = prev_state;
    contact_run_next = contact_run;
    release_run_next = release_run;
    up_run_next      = up_run;
    down_run_next    = down_run;
    change_time_next = change_time;
    ev               = EV_NONE;
    jump             = 1'b0;
    target           = state;

    if (accept) begin
      case (state)
        ST_FREE: begin
          if (cls != CLS_NONE) begin
            contact_run_next = contact_inc;
            if (CMP_W'(contact_inc) > CMP_W'(cfg.touch_count)) begin
              jump   = 1'b1;
              target = ST_TOUCH;
            end
          end
        end
        ST_TOUCH: begin
          if (cls == CLS_NONE) begin
            jump   = 1'b1;
            target = ST_FREE;
            ev     = EV_TOUCH;
          end else begin
            contact_run_next = contact_inc;
            if (reached(contact_inc, cfg.hold_count) &&
                elapsed > TIME_WIDTH'(cfg.hold_time_ms)) begin
              jump   = 1'b1;
              target = ST_HELD_INIT;
              ev     = EV_HOLD;
            end
          end
        end
        ST_HELD_INIT, ST_DOWN, ST_UP: begin
          case (cls)
            CLS_NONE: begin
              release_run_next = release_inc;
              if (reached(release_inc, cfg.release_count)) begin
                jump   = 1'b1;
                target = ST_FREE;
                ev     = EV_RELEASE;
              end
            end
            CLS_UP: begin
              if (state != ST_HELD_INIT) release_run_next = '0;
              up_run_next   = up_inc;
              down_run_next = '0;
              if (state != ST_UP && reached(up_inc, cfg.finger_up_count)) begin
                jump   = 1'b1;
                target = ST_UP;
              end
            end
            CLS_DOWN: begin
              if (state != ST_HELD_INIT) release_run_next = '0;
              up_run_next = '0;
              // finger-down state holds its down count untouched
              if (state != ST_DOWN) begin
                down_run_next = down_inc;
                if (reached(down_inc, cfg.finger_down_count)) begin
                  jump   = 1'b1;
                  target = ST_DOWN;
                  if (state == ST_UP && prev_state == ST_DOWN &&
                      elapsed < TIME_WIDTH'(cfg.click_window_ms)) begin
                    ev = EV_CLICK;
                  end
                end
              end
            end
            default: ;  // plain contact changes nothing in held states
          endcase
        end
        default: ;
      endcase

      if (jump) begin
        prev_state_next  = state;
        state_next       = target;
        contact_run_next = '0;
        release_run_next = '0;
        up_run_next      = '0;
        down_run_next    = '0;
        change_time_next = now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_FREE;
      prev_state  <= ST_FREE;
      contact_run <= '0;
      release_run <= '0;
      up_run      <= '0;
      down_run    <= '0;
      change_time <= '0;
    end else begin
      state       <= state_next;
      prev_state  <= prev_state_next;
      contact_run <= contact_run_next;
      release_run <= release_run_next;
      up_run      <= up_run_next;
      down_run    <= down_run_next;
      change_time <= change_time_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_state <= state_next;
      out_event <= ev;
    end
  end

  assign result.valid      = out_valid;
  assign result.hold_state = out_state;
  assign result.event_code = out_event;

  // Hold and click land in the state they name.
  a_hold_state: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_event == EV_HOLD |-> out_state == ST_HELD_INIT)
    else $error("hold event without held-init state");

  a_click_state: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_event == EV_CLICK |-> out_state == ST_DOWN)
    else $error("click event without finger-down state");

  a_free_events: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_event == EV_TOUCH || out_event == EV_RELEASE)
      |-> out_state == ST_FREE)
    else $error("touch or release event outside free state");

  // A state change clears every run counter.
  a_change_clears: assert property (@(posedge clk) disable iff (rst)
    accept && state_next != state |=>
      contact_run == '0 && release_run == '0 && up_run == '0 && down_run == '0)
    else $error("run counters not cleared on state change");

endmodule

// ----- rtl/thcg_cfg_regs.sv -----
// Configuration register file with write-only access.
module thcg_cfg_regs import thcg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.touch_count       <= RST_TOUCH_COUNT;
      cfg.hold_count        <= RST_HOLD_COUNT;
      cfg.hold_time_ms      <= RST_HOLD_TIME_MS;
      cfg.release_count     <= RST_RELEASE_COUNT;
      cfg.finger_down_count <= RST_FINGER_DOWN_COUNT;
      cfg.finger_up_count   <= RST_FINGER_UP_COUNT;
      cfg.click_window_ms   <= RST_CLICK_WINDOW_MS;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TOUCH_COUNT:       cfg.touch_count       <= cfg_data[THR_W-1:0];
        CFG_HOLD_COUNT:        cfg.hold_count        <= cfg_data[THR_W-1:0];
        CFG_HOLD_TIME_MS:      cfg.hold_time_ms      <= cfg_data[MS_W-1:0];
        CFG_RELEASE_COUNT:     cfg.release_count     <= cfg_data[THR_W-1:0];
        CFG_FINGER_DOWN_COUNT: cfg.finger_down_count <= cfg_data[THR_W-1:0];
        CFG_FINGER_UP_COUNT:   cfg.finger_up_count   <= cfg_data[THR_W-1:0];
        CFG_CLICK_WINDOW_MS:   cfg.click_window_ms   <= cfg_data[MS_W-1:0];
        default: ;
      endcase
    end
  end

endmodule
